// ===== sv/js_pkg.sv =====
// shared types and constants for the jacobi symbol unit
package js_pkg;

  localparam int unsigned DATA_WIDTH = 64;

  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } js_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } js_cmd_t;

  typedef struct packed {
    logic done;
  } js_status_t;

endpackage

// ===== sv/jacobi_symbol.sv =====
// jacobi symbol unit: top level joining sequencer and datapath
// a new item is taken only while idle, after the previous result has been shown
// the single subtract-and-shift step is reused for every iteration of the loop
// done_o strobes for one cycle; the receiver cannot stall, busy drops right after
// reset clears the sequencer to idle and sets the modulus register to 3
module jacobi_symbol import js_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  modulus_we_i,
  input  logic [DATA_WIDTH-1:0] modulus_i,
  output logic                  done_o,
  output logic signed [1:0]     symbol_o,
  output logic                  bad_modulus_o
);

  js_cmd_t    cmd;
  js_status_t status;

  js_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  js_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .modulus_we_i  (modulus_we_i),
    .modulus_i     (modulus_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .symbol_o      (symbol_o),
    .bad_modulus_o (bad_modulus_o)
  );

`ifndef SYNTHESIS
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result shown while idle");

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_modulus_o) |-> (symbol_o == SYM_ZERO))
    else $error("nonzero symbol with even modulus");

  a_sym_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (symbol_o != 2'sb10))
    else $error("illegal symbol code");

  a_start_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted item did not start the loop");
`endif

endmodule

// ===== sv/js_ctrl.sv =====
// sequencer for the jacobi symbol reduction loop
module js_ctrl import js_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  js_status_t status_i,
  output js_cmd_t    cmd_o,
  output logic       busy,
  output logic       done_o
);

  js_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status_i.done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/js_datapath.sv =====
// operand registers and binary jacobi reduction step
module js_datapath import js_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  modulus_we_i,
  input  logic [DATA_WIDTH-1:0] modulus_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  js_cmd_t               cmd_i,
  output js_status_t            status_o,
  output logic signed [1:0]     symbol_o,
  output logic                  bad_modulus_o
);

  logic [DATA_WIDTH-1:0] modulus_q;
  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] n_q, n_d;
  logic                  neg_q, neg_d;
  logic                  bad_q;
  logic signed [1:0]     sym_q;
  logic                  badout_q;
  logic [DATA_WIDTH:0]   a_minus_n;
  logic [DATA_WIDTH-1:0] n_minus_a;
  logic                  n_is_one;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= DATA_WIDTH'(3);
    end else if (modulus_we_i) begin
      modulus_q <= modulus_i;
    end
  end

  assign a_minus_n = {1'b0, a_q} - {1'b0, n_q};
  assign n_minus_a = n_q - a_q;
  assign n_is_one  = (n_q == DATA_WIDTH'(1));

  always_comb begin
    a_d   = a_q;
    n_d   = n_q;
    neg_d = neg_q;
    if (!a_q[0]) begin
      // strip a factor of two, (2/n) is -1 for n = 3 or 5 mod 8
      a_d = a_q >> 1;
      if (n_q[2:0] == 3'd3 || n_q[2:0] == 3'd5) begin
        neg_d = ~neg_q;
      end
    end else if (!a_minus_n[DATA_WIDTH]) begin
      a_d = a_minus_n[DATA_WIDTH-1:0];
    end else begin
      // a < n, both odd: swap by reciprocity and subtract
      a_d = n_minus_a;
      n_d = a_q;
      if (a_q[1:0] == 2'd3 && n_q[1:0] == 2'd3) begin
        neg_d = ~neg_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= value_i;
      n_q   <= modulus_q;
      neg_q <= 1'b0;
      bad_q <= ~modulus_q[0];
    end else if (cmd_i.step) begin
      a_q   <= a_d;
      n_q   <= n_d;
      neg_q <= neg_d;
    end
    if (cmd_i.finish) begin
      badout_q <= bad_q;
      if (!bad_q && n_is_one) begin
        sym_q <= neg_q ? SYM_NEG : SYM_POS;
      end else begin
        sym_q <= SYM_ZERO;
      end
    end
  end

  assign status_o.done = bad_q | (a_q == '0);
  assign symbol_o      = sym_q;
  assign bad_modulus_o = badout_q;

endmodule
